[hdl/adc_channel_averager_stop_pin_assert.svh]
// Assertion macros shared by the averager modules.
`ifndef ADC_CHANNEL_AVERAGER_STOP_PIN_ASSERT_SVH
`define ADC_CHANNEL_AVERAGER_STOP_PIN_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ACA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ACA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/aca_pkg.sv]
// Package with types, constants and commands of the ADC channel averager.
package aca_pkg;
  localparam int NUM_SLOTS_DEF = 4;
  localparam int HALVE_AT_DEF = 254;
  localparam logic [11:0] VCC_PLAIN_LIMIT = 12'd1862;
  localparam logic [24:0] RATIO_NUM = 25'd26214400;
  localparam logic [5:0] RATIO_DEN = 6'd33;
  localparam logic [7:0] VCC_CHAN_RST = 8'd4;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_PINS = 3'd1;
  localparam logic [2:0] REG_STOP = 3'd2;
  localparam logic [2:0] REG_SETTLE = 3'd3;
  localparam logic [2:0] REG_VCC = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SAMPLE, ST_SLOT, ST_RDIV, ST_ACC, ST_READ, ST_DIV, ST_RSTORE, ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input word
    logic pre_adv;   // advance stop pin if current one is invalid, update vcc
    logic slot_chk;  // evaluate slot_cnt for this sample
    logic rdiv_start;
    logic acc;       // add terms into slot
    logic slot_inc;
    logic read_chk;
    logic div_start;
    logic rstore;
    logic tick;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] op;
    logic slot_hit;
    logic slot_last;
    logic use_ratio;
    logic read_go;
    logic div_busy;
  } sts_t;
endpackage

[hdl/aca_divider.sv]
// Shared restoring divider, one quotient bit a cycle.
module aca_divider #(
  parameter int NW = 37,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          busy
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0] trial;

  always_comb begin
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    q_nxt = {q_r[NW-2:0], 1'b0};
    rem_nxt = trial;
    cnt_nxt = cnt_r;
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt[0] = 1'b1;
      end
    end else begin
      q_nxt = q_r;
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign quo = q_r;
  assign busy = (cnt_r != '0) || start;
endmodule

[hdl/aca_datapath.sv]
// Datapath of the averager: slot state, stop-pin rotation and arithmetic.
`include "adc_channel_averager_stop_pin_assert.svh"
module aca_datapath #(
  parameter int NUM_SLOTS = aca_pkg::NUM_SLOTS_DEF,
  parameter int HALVE_AT = aca_pkg::HALVE_AT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  aca_pkg::cmd_t   cmd,
  output aca_pkg::sts_t   sts,
  input  logic [1:0]      in_op,
  input  logic [7:0]      in_chan,
  input  logic [11:0]     in_data,
  input  logic [1:0]      in_slot,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_idx,
  input  logic [47:0]     cfg_val,
  output logic [55:0]     res
);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [3:0] en_r, stopm_r;
  logic [31:0] pins_r;
  logic [47:0] settle_r;
  logic [7:0] vccch_r;
  logic [1:0] op_r;
  logic [7:0] chan_r;
  logic [11:0] data_r;
  logic [1:0] slot_r;
  logic [27:0] sumc_r [NUM_SLOTS];
  logic [28:0] sumr_r [NUM_SLOTS];
  logic [7:0] cnt_r [NUM_SLOTS];
  logic [11:0] last_r [NUM_SLOTS];
  logic [19:0] havg_r [NUM_SLOTS];
  logic [20:0] hravg_r [NUM_SLOTS];
  logic [11:0] vcc_r;
  logic [SW-1:0] stop_r, stop_nxt;
  logic stop_upd;
  logic [31:0] ms_r, chg_r;
  logic [SW-1:0] sc_r;
  logic [55:0] res_r;
  logic div_sel_r;
  logic [36:0] dnum;
  logic [17:0] dden;
  logic [36:0] dquo;
  logic dbusy;
  logic [28:0] term_r;

  function automatic logic has_stop(input logic [3:0] en, input logic [3:0] sm,
                                    input int j);
    has_stop = (j < 4) && (j < NUM_SLOTS) && en[j & 3] && sm[j & 3];
  endfunction

  function automatic logic [7:0] pin_of(input logic [31:0] p, input int j);
    pin_of = p[8*(j & 3) +: 8];
  endfunction

  // Round-robin search from the current holder; the sum wraps at most once.
  always_comb begin
    int idx;
    stop_nxt = stop_r;
    stop_upd = 1'b0;
    for (int i = NUM_SLOTS; i >= 1; i--) begin
      idx = int'(stop_r) + i;
      if (idx >= NUM_SLOTS) idx = idx - NUM_SLOTS;
      if (has_stop(en_r, stopm_r, idx)) begin
        stop_nxt = SW'(idx);
        stop_upd = 1'b1;
      end
    end
  end

  logic cur_stop, hit, sc_stop, settled;
  logic [7:0] cnt_inc;
  always_comb begin
    cur_stop = has_stop(en_r, stopm_r, int'(stop_r));
    sc_stop = has_stop(en_r, stopm_r, int'(sc_r));
    settled = (ms_r - chg_r) > {20'd0, settle_r[12*(int'(sc_r) & 3) +: 12]};
    hit = (int'(sc_r) < 4) && en_r[int'(sc_r) & 3] && (pin_of(pins_r, int'(sc_r)) == chan_r)
          && (!sc_stop || ((stop_r == sc_r) && settled));
    cnt_inc = cnt_r[sc_r] + 8'd1;
  end

  assign sts.op = op_r;
  assign sts.slot_hit = hit;
  assign sts.slot_last = (int'(sc_r) == NUM_SLOTS - 1);
  assign sts.use_ratio = (vcc_r >= aca_pkg::VCC_PLAIN_LIMIT);
  assign sts.read_go = (int'(slot_r) < NUM_SLOTS) && (cnt_r[SW'(slot_r)] != 8'd0);
  assign sts.div_busy = dbusy;

  // Divider operands: ratio term or the two averages.
  always_comb begin
    dnum = '0;
    dden = '0;
    if (cmd.rdiv_start) begin
      dnum = 37'(data_r) * 37'(aca_pkg::RATIO_NUM);
      dden = 18'(vcc_r) * 18'(aca_pkg::RATIO_DEN);
    end else if (!div_sel_r) begin
      dnum = {9'd0, sumc_r[SW'(slot_r)]};
      dden = {10'd0, cnt_r[SW'(slot_r)]};
    end else begin
      dnum = {8'd0, sumr_r[SW'(slot_r)]};
      dden = {10'd0, cnt_r[SW'(slot_r)]};
    end
  end

  aca_divider #(.NW(37), .DW(18)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.rdiv_start || cmd.div_start),
    .num(dnum), .den(dden), .quo(dquo), .busy(dbusy)
  );

  always_ff @(posedge clk) begin
    logic [27:0] nc;
    logic [28:0] nr;
    logic [SW-1:0] rs;
    logic [55:0] ro;
    rs = SW'(slot_r);
    nc = sumc_r[sc_r] + {8'd0, data_r, 8'd0};
    nr = sumr_r[sc_r] + term_r;
    if (!rst_n) begin
      en_r <= '0; pins_r <= '0; stopm_r <= '0; settle_r <= '0;
      vccch_r <= aca_pkg::VCC_CHAN_RST;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        sumc_r[j] <= '0; sumr_r[j] <= '0; cnt_r[j] <= '0;
        last_r[j] <= '0; havg_r[j] <= '0; hravg_r[j] <= '0;
      end
      vcc_r <= '0; stop_r <= '0; ms_r <= '0; chg_r <= '0;
      sc_r <= '0; div_sel_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          aca_pkg::REG_ENABLE: en_r <= cfg_val[3:0];
          aca_pkg::REG_PINS:   pins_r <= cfg_val[31:0];
          aca_pkg::REG_STOP:   stopm_r <= cfg_val[3:0];
          aca_pkg::REG_SETTLE: settle_r <= cfg_val;
          aca_pkg::REG_VCC:    vccch_r <= cfg_val[7:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        op_r <= in_op; chan_r <= in_chan; data_r <= in_data; slot_r <= in_slot;
      end
      if (cmd.pre_adv) begin
        sc_r <= '0;
        if (!cur_stop && stop_upd) begin
          stop_r <= stop_nxt; chg_r <= ms_r;
        end
        if (chan_r == vccch_r) vcc_r <= data_r;
      end
      if (cmd.rdiv_start) term_r <= {9'd0, data_r, 8'd0};
      if (cmd.acc) begin
        if (sts.use_ratio) nr = sumr_r[sc_r] + dquo[28:0];
        last_r[sc_r] <= data_r;
        if (cnt_inc == 8'(HALVE_AT)) begin
          sumc_r[sc_r] <= nc >> 1; sumr_r[sc_r] <= nr >> 1; cnt_r[sc_r] <= cnt_inc >> 1;
        end else begin
          sumc_r[sc_r] <= nc; sumr_r[sc_r] <= nr; cnt_r[sc_r] <= cnt_inc;
        end
        if (sc_stop && stop_upd) begin
          stop_r <= stop_nxt; chg_r <= ms_r;
        end
      end
      if (cmd.slot_inc) sc_r <= sc_r + 1'b1;
      if (cmd.div_start) div_sel_r <= ~div_sel_r;
      if (cmd.rstore) begin
        if (div_sel_r) begin
          havg_r[rs] <= dquo[19:0];
        end else begin
          hravg_r[rs] <= dquo[20:0];
          sumc_r[rs] <= '0; sumr_r[rs] <= '0; cnt_r[rs] <= '0;
        end
      end
      if (cmd.tick) ms_r <= ms_r + 32'd1;
    end
    if (cmd.out_load) begin
      ro = '0;
      if (op_r == aca_pkg::OP_READ && int'(slot_r) < NUM_SLOTS) begin
        ro[19:0] = havg_r[rs];
        ro[40:20] = hravg_r[rs];
        ro[52:41] = last_r[rs];
      end
      ro[54:53] = 2'(stop_r);
      ro[55] = cur_stop;
      res_r <= ro;
    end
  end

  assign res = res_r;

  `ACA_ASSERT_IMP(a_stop_range, clk, rst_n, 1'b1, int'(stop_r) < NUM_SLOTS)
  `ACA_ASSERT_IMP(a_cnt_below, clk, rst_n, 1'b1, cnt_r[0] < 8'(HALVE_AT))
  `ACA_ASSERT_NXT(a_tick, clk, rst_n, cmd.tick, ms_r == $past(ms_r) + 32'd1)
endmodule

[hdl/aca_ctrl.sv]
// Controller state machine of the averager.
`include "adc_channel_averager_stop_pin_assert.svh"
module aca_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  output logic          busy,
  output logic          out_tvalid,
  input  logic          out_tready,
  output aca_pkg::cmd_t cmd,
  input  aca_pkg::sts_t sts
);
  aca_pkg::state_t st_r, st_nxt;
  logic ov_r, ov_nxt;
  logic second_r, second_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= aca_pkg::ST_IDLE; ov_r <= 1'b0; second_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; second_r <= second_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    second_nxt = second_r;
    ov_nxt = ov_r && !out_tready;
    unique case (st_r)
      aca_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          st_nxt = aca_pkg::ST_SAMPLE;
        end
      end
      aca_pkg::ST_SAMPLE: begin
        unique case (sts.op)
          aca_pkg::OP_SAMPLE: begin
            cmd.pre_adv = 1'b1; st_nxt = aca_pkg::ST_SLOT;
          end
          aca_pkg::OP_READ: st_nxt = aca_pkg::ST_READ;
          aca_pkg::OP_TICK: begin
            cmd.tick = 1'b1; st_nxt = aca_pkg::ST_OUT;
          end
          default: st_nxt = aca_pkg::ST_OUT;
        endcase
      end
      aca_pkg::ST_SLOT: begin
        if (sts.slot_hit) begin
          cmd.rdiv_start = 1'b1; st_nxt = aca_pkg::ST_RDIV;
        end else if (sts.slot_last) begin
          st_nxt = aca_pkg::ST_OUT;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      aca_pkg::ST_RDIV: if (!sts.div_busy) st_nxt = aca_pkg::ST_ACC;
      aca_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.slot_last) st_nxt = aca_pkg::ST_OUT;
        else begin
          cmd.slot_inc = 1'b1; st_nxt = aca_pkg::ST_SLOT;
        end
      end
      aca_pkg::ST_READ: begin
        if (sts.read_go) begin
          cmd.div_start = 1'b1; second_nxt = 1'b0; st_nxt = aca_pkg::ST_DIV;
        end else st_nxt = aca_pkg::ST_OUT;
      end
      aca_pkg::ST_DIV: if (!sts.div_busy) st_nxt = aca_pkg::ST_RSTORE;
      aca_pkg::ST_RSTORE: begin
        if (!second_r) begin
          cmd.rstore = 1'b1; cmd.div_start = 1'b1; second_nxt = 1'b1;
          st_nxt = aca_pkg::ST_DIV;
        end else begin
          cmd.rstore = 1'b1; st_nxt = aca_pkg::ST_OUT;
        end
      end
      aca_pkg::ST_OUT: begin
        if (!ov_r || out_tready) begin
          cmd.out_load = 1'b1; ov_nxt = 1'b1; st_nxt = aca_pkg::ST_IDLE;
        end
      end
      default: st_nxt = aca_pkg::ST_IDLE;
    endcase
  end

  assign busy = (st_r != aca_pkg::ST_IDLE);
  assign out_tvalid = ov_r;

  `ACA_ASSERT_IMP(a_fire_idle, clk, rst_n, in_fire, !busy)
  `ACA_ASSERT_NXT(a_out_set, clk, rst_n, cmd.out_load, out_tvalid)
  `ACA_ASSERT_IMP(a_one_start, clk, rst_n, cmd.div_start, !cmd.rdiv_start)
endmodule

[hdl/adc_channel_averager_stop_pin.sv]
// Top level of the ADC channel averager with stop-pin rotation.
// The block takes words on the in_ channel: ADC samples, average reads of a
// slot, and one-millisecond ticks, chosen by in_tuser. Every accepted word
// gives exactly one result word on the out_ channel, in order.
// Words are handled one at a time. A sample walks the slots one per cycle and
// waits on the shared bit-serial divider for each slot it updates; a read with
// samples pending uses two divider passes. The divider is what sets the rate.
// A finished result sits in the output register while the next word is
// accepted and worked on; if the receiver stalls, the block holds the next
// result until the register frees, and in_tready stays low meanwhile.
// Reset is synchronous and active low. It clears all sums, counts, held
// averages, the supply count, the stop-pin holder and the millisecond clock,
// and loads the default supply-sense channel. No clearing pass is needed.
// The user makes cfg_ configuration writes only while the block is idle; unenforced.
module adc_channel_averager_stop_pin #(
  parameter int NUM_SLOTS = aca_pkg::NUM_SLOTS_DEF,
  parameter int HALVE_AT = aca_pkg::HALVE_AT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // adc_channel[7:0], adc_data[19:8], slot_index[21:20]
  input  logic [1:0]  in_tuser,  // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // average_value[19:0], average_ratiometric[40:20], latest_value[52:41],
  // stop_select[54:53], stop_active[55]
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [47:0] cfg_wdata
);
  aca_pkg::cmd_t cmd;
  aca_pkg::sts_t sts;
  logic busy;
  logic in_fire;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  aca_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .busy(busy),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .sts(sts)
  );

  aca_datapath #(.NUM_SLOTS(NUM_SLOTS), .HALVE_AT(HALVE_AT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_tuser), .in_chan(in_tdata[7:0]), .in_data(in_tdata[19:8]),
    .in_slot(in_tdata[21:20]), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_val(cfg_wdata), .res(out_tdata)
  );
endmodule

[dv/aca_scoreboard.sv]
// Checker that predicts and compares every result word of the averager.
module aca_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [47:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [0:0]  act;
    logic [1:0]  sel;
    logic [11:0] last;
    logic [20:0] ravg;
    logic [19:0] avg;
  } avg_result_t;

  avg_result_t result_q[$];

  logic [3:0]  slot_en;
  logic [31:0] slot_pins;
  logic [3:0]  stop_mask;
  logic [47:0] settle_ms;
  logic [7:0]  vcc_chan;

  logic [27:0] sum_plain [4];
  logic [28:0] sum_rail [4];
  logic [7:0]  n_samples [4];
  logic [11:0] last_sample [4];
  logic [19:0] held_plain [4];
  logic [20:0] held_rail [4];
  logic [11:0] vcc_count;
  logic [1:0]  stop_holder;
  logic [31:0] ms_clock;
  logic [31:0] stop_since;

  function automatic bit has_stop(int j);
    return slot_en[j] && stop_mask[j];
  endfunction

  task automatic rotate_stop();
    int idx;
    for (int i = 1; i <= 4; i++) begin
      idx = (stop_holder + i) % 4;
      if (has_stop(idx)) begin
        stop_since = ms_clock;
        stop_holder = idx[1:0];
        return;
      end
    end
  endtask

  task automatic add_sample(int j, logic [11:0] v);
    logic [63:0] rail_term;
    last_sample[j] = v;
    sum_plain[j] = sum_plain[j] + {v, 8'h00};
    if (vcc_count < 12'd1862) begin
      rail_term = {v, 8'h00};
    end else begin
      rail_term = (64'(v) * 64'd26214400) / (64'd33 * 64'(vcc_count));
    end
    sum_rail[j] = sum_rail[j] + rail_term[28:0];
    n_samples[j] = n_samples[j] + 8'd1;
    // Halving keeps the running sums from overflowing on long runs.
    if (n_samples[j] == 8'd254) begin
      sum_plain[j] = sum_plain[j] >> 1;
      sum_rail[j] = sum_rail[j] >> 1;
      n_samples[j] = n_samples[j] >> 1;
    end
  endtask

  task automatic predict_word(logic [1:0] op, logic [23:0] d);
    logic [7:0]  ch;
    logic [11:0] v;
    logic [1:0]  s;
    avg_result_t r;
    ch = d[7:0];
    v = d[19:8];
    s = d[21:20];
    r = '0;
    if (op == aca_pkg::OP_SAMPLE) begin
      if (!has_stop(stop_holder)) rotate_stop();
      if (ch == vcc_chan) vcc_count = v;
      for (int j = 0; j < 4; j++) begin
        if (!slot_en[j] || slot_pins[8*j +: 8] != ch) continue;
        if (!has_stop(j)) begin
          add_sample(j, v);
        end else if (stop_holder == j &&
                     (ms_clock - stop_since) > 32'(settle_ms[12*j +: 12])) begin
          add_sample(j, v);
          rotate_stop();
        end
      end
    end else if (op == aca_pkg::OP_READ) begin
      if (n_samples[s] != 0) begin
        held_plain[s] = 20'(sum_plain[s] / n_samples[s]);
        held_rail[s] = 21'(sum_rail[s] / n_samples[s]);
        sum_plain[s] = '0;
        sum_rail[s] = '0;
        n_samples[s] = '0;
      end
      r.avg = held_plain[s];
      r.ravg = held_rail[s];
      r.last = last_sample[s];
    end else if (op == aca_pkg::OP_TICK) begin
      ms_clock = ms_clock + 1;
    end
    r.sel = stop_holder;
    r.act = has_stop(stop_holder);
    result_q.push_back(r);
  endtask

  assign pending = result_q.size();

  always @(posedge clk) begin
    avg_result_t got, exp_r;
    if (!rst_n) begin
      slot_en = '0;
      slot_pins = '0;
      stop_mask = '0;
      settle_ms = '0;
      vcc_chan = aca_pkg::VCC_CHAN_RST;
      for (int j = 0; j < 4; j++) begin
        sum_plain[j] = '0;
        sum_rail[j] = '0;
        n_samples[j] = '0;
        last_sample[j] = '0;
        held_plain[j] = '0;
        held_rail[j] = '0;
      end
      vcc_count = '0;
      stop_holder = '0;
      ms_clock = '0;
      stop_since = '0;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          aca_pkg::REG_ENABLE: slot_en = cfg_wdata[3:0];
          aca_pkg::REG_PINS:   slot_pins = cfg_wdata[31:0];
          aca_pkg::REG_STOP:   stop_mask = cfg_wdata[3:0];
          aca_pkg::REG_SETTLE: settle_ms = cfg_wdata;
          aca_pkg::REG_VCC:    vcc_chan = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (result_q.size() == 0) begin
          $error("result word with no expectation: %h", out_tdata);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (got.avg !== exp_r.avg) begin
            $error("average_value expected %0d got %0d", exp_r.avg, got.avg);
            fail_count++;
          end
          if (got.ravg !== exp_r.ravg) begin
            $error("average_ratiometric expected %0d got %0d", exp_r.ravg, got.ravg);
            fail_count++;
          end
          if (got.last !== exp_r.last) begin
            $error("latest_value expected %0d got %0d", exp_r.last, got.last);
            fail_count++;
          end
          if (got.sel !== exp_r.sel) begin
            $error("stop_select expected %0d got %0d", exp_r.sel, got.sel);
            fail_count++;
          end
          if (got.act !== exp_r.act) begin
            $error("stop_active expected %0d got %0d", exp_r.act, got.act);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

[dv/adc_channel_averager_stop_pin_tb.sv]
// Top of the averager testbench: clock, reset, stimulus and verdict.
module adc_channel_averager_stop_pin_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // adc_channel[7:0], adc_data[19:8], slot_index[21:20]
  logic [1:0]  in_tuser;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  // average_value[19:0], average_ratiometric[40:20], latest_value[52:41],
  // stop_select[54:53], stop_active[55]
  logic [55:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [47:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          burst_left;

  // Shadow copies of what the block was last given, used to aim samples.
  logic [31:0] cur_pins;
  logic [7:0]  cur_vcc;

  // A margin that covers a busy word draining.
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT = 2_000_000;

  adc_channel_averager_stop_pin uut (.*);

  aca_scoreboard checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The receiver changes its stall style in turn: always
  // ready, randomly stalling, or a fixed duty pattern.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 300) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 99) < 65);
      default: out_tready <= ((cycle_count % 7) < 4);
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it. The sender works
  // in bursts; between bursts it drops valid for a random gap.
  task automatic send_word(logic [1:0] op, logic [7:0] ch, logic [11:0] v,
                           logic [1:0] s);
    in_tuser <= op;
    in_tdata <= {2'b00, s, v, ch};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Let every expected word arrive, then give a busy sample time to finish.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The enable stays high for back-to-back writes; the caller drops it.
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(logic [3:0] en, logic [31:0] pins, logic [3:0] stops,
                           logic [47:0] settle, logic [7:0] vcc);
    drain();
    write_reg(aca_pkg::REG_ENABLE, 48'(en));
    write_reg(aca_pkg::REG_PINS, 48'(pins));
    write_reg(aca_pkg::REG_STOP, 48'(stops));
    write_reg(aca_pkg::REG_SETTLE, settle);
    write_reg(aca_pkg::REG_VCC, 48'(vcc));
    cfg_we <= 1'b0;
    cur_pins = pins;
    cur_vcc = vcc;
  endtask

  // Supply samples straddle the 3.0 V threshold so both ratiometric paths run.
  function automatic logic [11:0] vcc_level();
    return ($urandom_range(0, 1) != 0) ? 12'($urandom_range(1862, 4095))
                                       : 12'($urandom_range(0, 1861));
  endfunction

  // Mostly samples aimed at configured pins, with reads and ticks mixed in so
  // stop-pin slots settle and rotate; a few stray channels and unknown opcodes.
  task automatic random_word();
    int r;
    int k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 3);
    if (r < 35) begin
      send_word(aca_pkg::OP_SAMPLE, cur_pins[8*k +: 8], 12'($urandom_range(0, 4095)),
                2'd0);
    end else if (r < 45) begin
      send_word(aca_pkg::OP_SAMPLE, cur_vcc, vcc_level(), 2'($urandom_range(0, 3)));
    end else if (r < 52) begin
      send_word(aca_pkg::OP_SAMPLE, 8'($urandom_range(0, 255)),
                12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)));
    end else if (r < 67) begin
      send_word(aca_pkg::OP_READ, 8'($urandom_range(0, 255)),
                12'($urandom_range(0, 4095)), 2'(k));
    end else if (r < 96) begin
      send_word(aca_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)));
    end else begin
      send_word(aca_pkg::OP_IGNORED, 8'($urandom_range(0, 255)),
                12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)));
    end
  endtask

  function automatic logic [47:0] short_settles();
    logic [47:0] t;
    for (int j = 0; j < 4; j++) t[12*j +: 12] = 12'($urandom_range(0, 4));
    return t;
  endfunction

  initial begin
    logic [31:0] pins;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_wdata = '0;
    burst_left = 0;
    cur_pins = '0;
    cur_vcc = aca_pkg::VCC_CHAN_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset settings: nothing enabled, so reads return zeros and no stop pin
    // is held. Empty reads, an unknown opcode and extreme fields.
    send_word(aca_pkg::OP_SAMPLE, 8'd4, 12'd0, 2'd3);
    send_word(aca_pkg::OP_READ, 8'd0, 12'd0, 2'd0);
    send_word(aca_pkg::OP_READ, 8'hFF, 12'hFFF, 2'd3);
    send_word(aca_pkg::OP_TICK, 8'd0, 12'd0, 2'd0);
    send_word(aca_pkg::OP_IGNORED, 8'hFF, 12'hFFF, 2'd3);
    send_word(aca_pkg::OP_SAMPLE, 8'hFF, 12'hFFF, 2'd0);

    // All slots plain. Samples across the supply threshold on both sides.
    configure(4'hF, 32'hFF80_0100, 4'h0, 48'h0, 8'hFE);
    send_word(aca_pkg::OP_SAMPLE, 8'hFE, 12'hFFF, 2'd0);
    send_word(aca_pkg::OP_SAMPLE, 8'h00, 12'hFFF, 2'd0);
    send_word(aca_pkg::OP_SAMPLE, 8'hFF, 12'd0, 2'd0);
    send_word(aca_pkg::OP_SAMPLE, 8'hFE, 12'd1861, 2'd0);
    send_word(aca_pkg::OP_SAMPLE, 8'h01, 12'hABC, 2'd0);
    send_word(aca_pkg::OP_SAMPLE, 8'hFE, 12'd1862, 2'd0);
    send_word(aca_pkg::OP_SAMPLE, 8'h80, 12'd1, 2'd0);
    send_word(aca_pkg::OP_READ, 8'd0, 12'd0, 2'd0);
    send_word(aca_pkg::OP_READ, 8'd0, 12'd0, 2'd0);
    send_word(aca_pkg::OP_READ, 8'd0, 12'd0, 2'd1);
    send_word(aca_pkg::OP_READ, 8'd0, 12'd0, 2'd2);
    send_word(aca_pkg::OP_READ, 8'd0, 12'd0, 2'd3);

    // Long run on one slot so its count reaches the halving point.
    configure(4'h1, 32'h0000_0055, 4'h0, 48'h0, 8'h04);
    for (int i = 0; i < 260; i++) begin
      send_word(aca_pkg::OP_SAMPLE, 8'h55, 12'($urandom_range(0, 4095)), 2'd0);
    end
    send_word(aca_pkg::OP_READ, 8'd0, 12'd0, 2'd0);

    // Stop pins with settle times at the top of the range: slots never settle.
    configure(4'hF, 32'h0302_0100, 4'hF, 48'hFFFF_FFFF_FFFF, 8'hFF);
    repeat (40) random_word();

    // Random settings with short settle times so the stop pin rotates often.
    for (int p = 0; p < 4; p++) begin
      pins = $urandom();
      if (p == 0) pins = 32'h0403_0201;
      configure(4'($urandom_range(0, 15)) | (p == 0 ? 4'hF : 4'h0), pins,
                4'($urandom_range(0, 15)), short_settles(), 8'($urandom_range(0, 255)));
      for (int i = 0; i < 34; i++) begin
        random_word();
        // Hold off once mid-phase until every result is back.
        if (i == 17 && p == 2) drain();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/aca_pkg.sv
hdl/aca_divider.sv
hdl/aca_datapath.sv
hdl/aca_ctrl.sv
hdl/adc_channel_averager_stop_pin.sv
dv/aca_scoreboard.sv
dv/adc_channel_averager_stop_pin_tb.sv
